// File: hdl/stip_pkg.sv
package stip_pkg;

    // Field widths
    localparam int CH_W    = 8;
    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 64;
    localparam int OFFS_W  = 13;

    typedef logic [CH_W-1:0]    ch_t;
    typedef logic [BASE_W-1:0]  base_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [OFFS_W-1:0]  offs_t;

    // Radix codes
    localparam base_t BASE_AUTO  = 6'd0;
    localparam base_t BASE_UNARY = 6'd1;
    localparam base_t BASE_OCT   = 6'd8;
    localparam base_t BASE_DEC   = 6'd10;
    localparam base_t BASE_HEX   = 6'd16;
    localparam base_t BASE_MAX   = 6'd36;

    // Digit value of a character that is no digit at all
    localparam digit_t NO_DIGIT = 6'd36;

    // Characters of interest
    localparam ch_t CH_TAB   = 8'h09;
    localparam ch_t CH_SPACE = 8'h20;
    localparam ch_t CH_PLUS  = 8'h2B;
    localparam ch_t CH_MINUS = 8'h2D;
    localparam ch_t CH_ZERO  = 8'h30;
    localparam ch_t CH_NINE  = 8'h39;
    localparam ch_t CH_UA    = 8'h41;
    localparam ch_t CH_UZ    = 8'h5A;
    localparam ch_t CH_UX    = 8'h58;
    localparam ch_t CH_LA    = 8'h61;
    localparam ch_t CH_LZ    = 8'h7A;
    localparam ch_t CH_LX    = 8'h78;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic   first;
        digit_t digit;
        logic   blank;
        logic   sign;
        logic   minus;
        logic   zero;
        logic   xchar;
        base_t  base;
    } q_item_t;

    // Digit value 0..35, NO_DIGIT otherwise
    function automatic digit_t digit_of(input ch_t c);
        digit_t d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = DIGIT_W'(c - CH_ZERO);
        else if (c >= CH_LA && c <= CH_LZ)
            d = DIGIT_W'(c - CH_LA + 8'd10);
        else if (c >= CH_UA && c <= CH_UZ)
            d = DIGIT_W'(c - CH_UA + 8'd10);
        return d;
    endfunction

endpackage

// File: hdl/stip_if.sv
interface stip_in_if import stip_pkg::*; ();
    logic valid;
    logic ready;
    ch_t  ch;
    logic first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

interface stip_out_if import stip_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    offs_t                     end_offset;

    modport source (output valid, output value, output end_offset, input ready);
    modport sink   (input valid, input value, input end_offset, output ready);
endinterface

interface stip_cfg_if import stip_pkg::*; ();
    logic  valid;
    logic  ready;
    base_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/stip_front.sv
module stip_front import stip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    stip_cfg_if.sink    cfg,
    stip_in_if.sink     char_in,
    input  logic        q_ready,
    output logic        q_push,
    output q_item_t     q_item
);

    base_t number_base_reg;
    base_t number_base_next;

    // Base register, always writable
    assign cfg.ready = 1'b1;

    always_comb
    begin
        number_base_next = number_base_reg;
        if (cfg.valid)
            number_base_next = cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            number_base_reg <= BASE_AUTO;
        else
            number_base_reg <= number_base_next;
    end

    // Accept while the queue has room
    assign char_in.ready = q_ready;
    assign q_push        = char_in.valid && q_ready;

    // Classify the character
    always_comb
    begin
        q_item.first = char_in.first;
        q_item.digit = digit_of(char_in.ch);
        q_item.blank = (char_in.ch == CH_SPACE) || (char_in.ch == CH_TAB);
        q_item.sign  = (char_in.ch == CH_PLUS) || (char_in.ch == CH_MINUS);
        q_item.minus = (char_in.ch == CH_MINUS);
        q_item.zero  = (char_in.ch == CH_ZERO);
        q_item.xchar = (char_in.ch == CH_LX) || (char_in.ch == CH_UX);
        q_item.base  = number_base_reg;
    end

endmodule

// File: hdl/stip_queue.sv
module stip_queue import stip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    push_ready,
    input  logic    pop,
    output logic    head_valid,
    output q_item_t head_item
);

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: hdl/stip_back.sv
module stip_back import stip_pkg::*;
#(
    parameter int MAX_CHARS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  q_item_t     head_item,
    output logic        pop,
    stip_out_if.source  result_out
);

    localparam int    OFFS_MAX  = (1 << OFFS_W) - 1;
    localparam offs_t SAT_LIMIT = (MAX_CHARS < OFFS_MAX) ? OFFS_W'(MAX_CHARS)
                                                         : OFFS_W'(OFFS_MAX);

    // Parse phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_XSEEN  = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    value_t     accum_reg;
    value_t     accum_next;
    logic       neg_reg;
    logic       neg_next;
    base_t      abase_reg;
    base_t      abase_next;
    offs_t      cons_reg;
    offs_t      cons_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    value_t     value_reg;
    value_t     value_next;
    offs_t      offs_reg;
    offs_t      offs_next;

    logic [2:0] cur_phase;
    value_t     cur_accum;
    logic       cur_neg;
    base_t      cur_base;
    offs_t      cur_cons;
    base_t      mul_base;
    value_t     mac;
    logic [OFFS_W:0] sum1;
    logic [OFFS_W:0] sum2;
    offs_t      cons_p1;
    offs_t      cons_p2;
    logic       emit;
    value_t     emit_val;
    offs_t      emit_offs;
    logic       bad_base;
    base_t      dec_base;
    base_t      oct_base;

    // Take the next item whenever the output slot is free or draining
    assign pop = head_valid && (!out_valid_reg || result_out.ready);

    // A new string restarts from a clean state
    always_comb
    begin
        if (head_item.first)
        begin
            cur_phase = PH_LEAD;
            cur_accum = '0;
            cur_neg   = 1'b0;
            cur_base  = head_item.base;
            cur_cons  = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_accum = accum_reg;
            cur_neg   = neg_reg;
            cur_base  = abase_reg;
            cur_cons  = cons_reg;
        end
    end

    // Saturating consumed count
    assign sum1    = {1'b0, cur_cons} + (OFFS_W+1)'(1);
    assign sum2    = {1'b0, cur_cons} + (OFFS_W+1)'(2);
    assign cons_p1 = (sum1 > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : sum1[OFFS_W-1:0];
    assign cons_p2 = (sum2 > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : sum2[OFFS_W-1:0];

    // Radix fallbacks when auto detection is still open
    assign dec_base = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
    assign oct_base = (cur_base == BASE_AUTO) ? BASE_OCT : cur_base;
    assign bad_base = (cur_base == BASE_UNARY) || (cur_base > BASE_MAX);

    // Shared multiply-accumulate
    assign mul_base = (cur_phase == PH_ZERO) ? oct_base : cur_base;
    assign mac      = cur_accum * VALUE_W'(mul_base) + VALUE_W'(head_item.digit);

    // Phase sequencer
    always_comb
    begin
        phase_next = cur_phase;
        accum_next = cur_accum;
        neg_next   = cur_neg;
        abase_next = cur_base;
        cons_next  = cur_cons;
        emit       = 1'b0;
        emit_val   = '0;
        emit_offs  = '0;

        if (head_item.first && bad_base)
        begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
        end
        else
        begin
            unique case (cur_phase) inside
                PH_IDLE:
                begin
                end
                PH_LEAD, PH_SIGNED:
                begin
                    if (cur_phase == PH_LEAD && head_item.blank)
                        cons_next = cons_p1;
                    else if (cur_phase == PH_LEAD && head_item.sign)
                    begin
                        neg_next   = head_item.minus;
                        cons_next  = cons_p1;
                        phase_next = PH_SIGNED;
                    end
                    else if (head_item.zero
                             && (cur_base == BASE_AUTO || cur_base == BASE_HEX))
                    begin
                        cons_next  = cons_p1;
                        accum_next = '0;
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        abase_next = dec_base;
                        if (head_item.digit < dec_base)
                        begin
                            cons_next  = cons_p1;
                            accum_next = VALUE_W'(head_item.digit);
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_ZERO:
                begin
                    if (head_item.xchar)
                    begin
                        abase_next = BASE_HEX;
                        phase_next = PH_XSEEN;
                    end
                    else
                    begin
                        abase_next = oct_base;
                        if (head_item.digit < oct_base)
                        begin
                            accum_next = mac;
                            cons_next  = cons_p1;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            emit_val   = cur_accum;
                            emit_offs  = cur_cons;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_XSEEN:
                begin
                    if (head_item.digit < BASE_HEX)
                    begin
                        cons_next  = cons_p2;
                        accum_next = VALUE_W'(head_item.digit);
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_offs  = cur_cons;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DIGITS:
                begin
                    if (head_item.digit < cur_base)
                    begin
                        accum_next = mac;
                        cons_next  = cons_p1;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_val   = cur_accum;
                        emit_offs  = cur_cons;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Output slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        offs_next      = offs_reg;
        if (out_valid_reg && result_out.ready)
            out_valid_next = 1'b0;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            value_next     = cur_neg ? (VALUE_W'(0) - emit_val) : emit_val;
            offs_next      = emit_offs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            accum_reg     <= '0;
            neg_reg       <= 1'b0;
            abase_reg     <= '0;
            cons_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                accum_reg <= accum_next;
                neg_reg   <= neg_next;
                abase_reg <= abase_next;
                cons_reg  <= cons_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        offs_reg  <= offs_next;
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.value      = value_reg;
    assign result_out.end_offset = offs_reg;

endmodule

// File: hdl/string_to_integer_parser_top.sv
// strtol-style parser, one character item per clock while the queue has room.
// Throughput: one character per cycle while the queue has room, using the 64x6 multiply-add in the back end.
// With no backlog the stopping character is written into a queue entry when accepted, and the back end
// then loads its result into the output register.
// Reset (rst_n, async, low): queue empty, no result pending, parser idle, base = 0.
module string_to_integer_parser_top import stip_pkg::*;
#(
    parameter int MAX_CHARS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    stip_cfg_if.sink    cfg,
    stip_in_if.sink     char_in,
    stip_out_if.source  result_out
);

    logic    q_push;
    logic    q_ready;
    q_item_t q_push_item;
    logic    head_valid;
    q_item_t head_item;
    logic    pop;

    // Classification and base register
    stip_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .char_in (char_in),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_item  (q_push_item)
    );

    // Decoupling queue
    stip_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .push_ready (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Parse sequencer and result register
    stip_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

// File: test/string_to_integer_parser_top_tb.sv
`timescale 1ns / 100ps

module string_to_integer_parser_top_tb import stip_pkg::*; ();

    localparam int SAT_CHARS    = 4096;
    localparam int SAT_LIMIT    = (SAT_CHARS < 8191) ? SAT_CHARS : 8191;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_CHARS  = 70;
    localparam int LONG_RUN     = 180;
    localparam ch_t CH_NUL      = 8'h00;

    typedef enum logic [2:0] {
        P_IDLE, P_LEAD, P_SIGNED, P_ZERO, P_XSEEN, P_DIGITS
    } parse_phase_t;

    typedef struct {
        value_t value;
        offs_t  end_offset;
    } parse_result_t;

    logic clk;
    logic rst_n;

    stip_cfg_if cfg_bus();
    stip_in_if  char_bus();
    stip_out_if result_bus();

    string_to_integer_parser_top #(.MAX_CHARS(SAT_CHARS)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .char_in    (char_bus),
        .result_out (result_bus)
    );

    // Parser state mirrored in the bench
    parse_phase_t ph;
    value_t       acc;
    logic         neg;
    base_t        cur_base;
    base_t        base_reg;
    offs_t        used;

    parse_result_t pending_parses[$];

    int  errors = 0;
    int  results_seen = 0;
    int  items_sent;
    int  strings_sent;
    int  base_writes;
    int  burst_left;
    int  gap;
    int  cycle_cnt = 0;
    int  hold_requests;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_parses.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Digit value of a character, 36 when it is no digit
    function automatic digit_t char_digit(input ch_t c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return digit_t'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LZ)
            return digit_t'(c - CH_LA + 10);
        if (c >= CH_UA && c <= CH_UZ)
            return digit_t'(c - CH_UA + 10);
        return NO_DIGIT;
    endfunction

    // Count consumed characters, saturating
    function automatic void bump(input int k);
        int n;
        n = int'(used) + k;
        used = (n > SAT_LIMIT) ? offs_t'(SAT_LIMIT) : offs_t'(n);
    endfunction

    function automatic bit close_string(input value_t mag, input offs_t at,
                                        output value_t v, output offs_t off);
        v   = neg ? value_t'(0) - mag : mag;
        off = at;
        ph  = P_IDLE;
        return 1'b1;
    endfunction

    // Advance the parser by one character; 1 when a result comes out
    function automatic bit parse_char(input ch_t c, input logic f,
                                      output value_t v, output offs_t off);
        digit_t d;
        d   = char_digit(c);
        v   = '0;
        off = '0;
        if (f)
        begin
            acc      = '0;
            neg      = 1'b0;
            used     = '0;
            cur_base = base_reg;
            ph       = P_LEAD;
            if (cur_base == BASE_UNARY || cur_base > BASE_MAX)
                return close_string('0, '0, v, off);
        end
        case (ph) inside
            P_LEAD, P_SIGNED:
            begin
                if (ph == P_LEAD && (c == CH_SPACE || c == CH_TAB))
                begin
                    bump(1);
                    return 1'b0;
                end
                if (ph == P_LEAD && (c == CH_PLUS || c == CH_MINUS))
                begin
                    neg = (c == CH_MINUS);
                    bump(1);
                    ph = P_SIGNED;
                    return 1'b0;
                end
                if (c == CH_ZERO && (cur_base == BASE_AUTO || cur_base == BASE_HEX))
                begin
                    bump(1);
                    acc = '0;
                    ph  = P_ZERO;
                    return 1'b0;
                end
                if (cur_base == BASE_AUTO)
                    cur_base = BASE_DEC;
                if (d < cur_base)
                begin
                    bump(1);
                    acc = value_t'(d);
                    ph  = P_DIGITS;
                    return 1'b0;
                end
                return close_string('0, '0, v, off);
            end
            P_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                begin
                    cur_base = BASE_HEX;
                    ph       = P_XSEEN;
                    return 1'b0;
                end
                if (cur_base == BASE_AUTO)
                    cur_base = BASE_OCT;
                ph = P_DIGITS;
                if (d < cur_base)
                begin
                    acc = acc * value_t'(cur_base) + value_t'(d);
                    bump(1);
                    return 1'b0;
                end
                return close_string(acc, used, v, off);
            end
            P_XSEEN:
            begin
                if (d < BASE_HEX)
                begin
                    bump(2);
                    acc = value_t'(d);
                    ph  = P_DIGITS;
                    return 1'b0;
                end
                return close_string('0, used, v, off);
            end
            P_DIGITS:
            begin
                if (d < cur_base)
                begin
                    acc = acc * value_t'(cur_base) + value_t'(d);
                    bump(1);
                    return 1'b0;
                end
                return close_string(acc, used, v, off);
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Send one character item, predict, then maybe idle between bursts
    task automatic send_char(input ch_t c, input logic f);
        value_t        v;
        offs_t         off;
        parse_result_t r;
        char_bus.valid <= 1'b1;
        char_bus.ch    <= c;
        char_bus.first <= f;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        items_sent++;
        if (f)
            strings_sent++;
        if (parse_char(c, f, v, off))
        begin
            r.value      = v;
            r.end_offset = off;
            pending_parses.push_back(r);
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(input string s, input bit start);
        for (int i = 0; i < s.len(); i++)
            send_char(ch_t'(s[i]), start && i == 0);
    endtask

    // Stop sending and wait until every result is in and the pipe is empty
    task automatic wait_idle();
        char_bus.valid <= 1'b0;
        while (pending_parses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Radix register write; only called while the block is idle
    task automatic set_base(input base_t b);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= b;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        base_reg = b;
        base_writes++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        parse_result_t exp_r;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            results_seen++;
            if (pending_parses.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d end_offset=%0d", $time,
                         $signed(result_bus.value), result_bus.end_offset);
                errors++;
            end
            else
            begin
                exp_r = pending_parses.pop_front();
                if (result_bus.value !== exp_r.value)
                begin
                    $display("%0t: value expected %0d actual %0d", $time,
                             $signed(exp_r.value), $signed(result_bus.value));
                    errors++;
                end
                if (result_bus.end_offset !== exp_r.end_offset)
                begin
                    $display("%0t: end_offset expected %0d actual %0d", $time,
                             exp_r.end_offset, result_bus.end_offset);
                    errors++;
                end
            end
        end
    end

    // Result receiver: own stall pattern, plus a long hold-off on request
    initial
    begin
        int rx_tick;
        int hold_left;
        int holds_taken;
        rx_tick     = 0;
        hold_left   = 0;
        holds_taken = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (hold_requests != holds_taken)
            begin
                holds_taken = hold_requests;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case ((rx_tick / 97) % 4)
                    0:       result_bus.ready <= 1'b1;
                    1:       result_bus.ready <= ($urandom_range(0, 9) < 7);
                    2:       result_bus.ready <= ((rx_tick % 5) < 2);
                    default: result_bus.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Special cases, short and by hand
    task automatic test_directed();
        // auto-detect base from reset
        send_text("\t-0x1F", 1'b1);
        send_char(CH_NUL, 1'b0);
        // hex prefix with no hex digit after it
        send_text("0xg", 1'b1);
        // sign and nothing else
        send_text("+ ", 1'b1);
        // unfinished string abandoned by a new one
        send_text("12", 1'b1);
        send_text("7", 1'b1);
        send_char(CH_NUL, 1'b0);
        // stray character while idle
        send_char(ch_t'("z"), 1'b0);
        // octal, stopped by a high byte
        send_text("017", 1'b1);
        send_char(8'hFF, 1'b0);
        // invalid radix converts nothing
        wait_idle();
        set_base(BASE_UNARY);
        send_text("A5", 1'b1);
    endtask

    // Largest and smallest value
    task automatic test_extremes();
        wait_idle();
        set_base(BASE_HEX);
        send_text("7FFFFFFFFFFFFFFF", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_text("-8000000000000000,", 1'b1);
    endtask

    // Offset counter on a long blank run
    task automatic test_long_string();
        wait_idle();
        set_base(BASE_DEC);
        for (int i = 0; i < LONG_RUN; i++)
            send_char(CH_SPACE, i == 0);
        send_text("9", 1'b0);
        send_char(CH_NUL, 1'b0);
    endtask

    // Receiver holds off while short strings keep coming, then the sender waits
    task automatic test_backpressure();
        wait_idle();
        hold_requests++;
        for (int i = 0; i < 40; i++)
        begin
            send_char(ch_t'(CH_ZERO + (i % 10)), 1'b1);
            send_char(CH_NUL, 1'b0);
        end
        wait_idle();
        for (int i = 0; i < 10; i++)
        begin
            send_text("-3", 1'b1);
            send_char(CH_NUL, 1'b0);
        end
        wait_idle();
    endtask

    // One random string, mostly well formed for the current radix
    task automatic send_random_string();
        ch_t text[$];
        int  eff;
        int  n;
        int  dv;
        if ($urandom_range(0, 19) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_char(ch_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)));
            return;
        end
        // leading blanks
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        // sign
        case ($urandom_range(0, 5)) inside
            [0:1]:   text.push_back(CH_MINUS);
            2:       text.push_back(CH_PLUS);
            default: ;
        endcase
        // prefix
        eff = int'(base_reg);
        if (base_reg == BASE_AUTO || base_reg == BASE_HEX)
        begin
            case ($urandom_range(0, 3))
                1:
                begin
                    text.push_back(CH_ZERO);
                    if (base_reg == BASE_AUTO)
                        eff = int'(BASE_OCT);
                end
                2:
                begin
                    text.push_back(CH_ZERO);
                    text.push_back(CH_LX);
                    eff = int'(BASE_HEX);
                end
                3:
                begin
                    text.push_back(CH_ZERO);
                    text.push_back(CH_UX);
                    eff = int'(BASE_HEX);
                end
                default: ;
            endcase
        end
        if (eff == 0)
            eff = int'(BASE_DEC);
        if (eff < 2 || eff > 36)
            eff = 36;
        // digits, now and then a long run that wraps
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
        repeat (n)
        begin
            dv = $urandom_range(0, eff - 1);
            if ($urandom_range(0, 29) == 0)
                text.push_back(ch_t'($urandom_range(0, 255)));
            else if (dv < 10)
                text.push_back(ch_t'(CH_ZERO + dv));
            else
                text.push_back(ch_t'(($urandom_range(0, 1) ? CH_LA : CH_UA) + dv - 10));
        end
        // stopping character, or none so the next string cuts this one off
        case ($urandom_range(0, 9)) inside
            0:       ;
            [1:4]:   text.push_back(CH_NUL);
            [5:6]:   text.push_back(ch_t'($urandom_range(0, 255)));
            default: text.push_back(ch_t'($urandom_range(8'h21, 8'h2F)));
        endcase
        if (text.size() == 0)
            text.push_back(ch_t'($urandom_range(0, 255)));
        foreach (text[i])
            send_char(text[i], i == 0);
        // trailing junk
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 2);
            repeat (n) send_char(ch_t'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Random strings over a sweep of radix settings
    task automatic test_random();
        base_t plan[12] = '{BASE_AUTO, BASE_DEC, BASE_HEX, 6'd2, BASE_MAX, BASE_OCT,
                            6'd37, 6'd63, BASE_UNARY, 6'd7, 6'd23, BASE_AUTO};
        int    start;
        for (int p = 0; p <= 12; p++)
        begin
            wait_idle();
            if (p < 12)
                set_base(plan[p]);
            else
                set_base(base_t'($urandom_range(0, 63)));
            start = items_sent;
            while (items_sent - start < PHASE_CHARS)
                send_random_string();
        end
    endtask

    // Main sequence
    initial
    begin
        items_sent    = 0;
        strings_sent  = 0;
        base_writes   = 0;
        hold_requests = 0;
        burst_left    = $urandom_range(1, 24);
        gap           = 0;
        ph            = P_IDLE;
        acc           = '0;
        neg           = 1'b0;
        cur_base      = BASE_AUTO;
        base_reg      = BASE_AUTO;
        used          = '0;
        rst_n          <= 1'b0;
        char_bus.valid <= 1'b0;
        char_bus.ch    <= CH_NUL;
        char_bus.first <= 1'b0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.data   <= BASE_AUTO;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extremes();
        test_long_string();
        test_backpressure();
        test_random();
        wait_idle();

        $display("Run covered %0d strings in %0d character items under %0d radix writes,",
                 strings_sent, items_sent, base_writes);
        $display("with %0d results compared and one long receiver hold-off.", results_seen);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/stip_pkg.sv
hdl/stip_if.sv
hdl/stip_front.sv
hdl/stip_queue.sv
hdl/stip_back.sv
hdl/string_to_integer_parser_top.sv
test/string_to_integer_parser_top_tb.sv
